>>> rtl/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg: shared types and constants of the WAV chunk parser
// Holds the parse phases, the chunk tags, the fmt defaults and the fixed-point
// gain constants used by the parser, the scaler and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wcp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_BODY = 3'd2,
    PH_PAD  = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_SAMPLE = 2'd0,
    ST_ENDED  = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] DEF_CHANNELS = 16'd2;
  localparam logic [31:0] DEF_RATE     = 32'd44100;
  localparam logic [15:0] DEF_DEPTH    = 16'd16;

  // Byte positions that close the RIFF magic, the RIFF header and a chunk header.
  localparam logic [31:0] RIFF_MAGIC_LAST = 32'd3;
  localparam logic [31:0] RIFF_HDR_LAST   = 32'd11;
  localparam logic [31:0] CHUNK_HDR_LAST  = 32'd7;

  // Gain is volume * 6 * ceil(2^35 / 1000); the product shifted right by 35
  // gives trunc(|s| * volume * 6 / 1000) exactly for every 16-bit sample.
  localparam int unsigned GAIN_W      = 35;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [6:0]  VOL_RESET   = 7'd50;
  localparam logic [6:0]  VOL_MAX     = 7'd100;
  localparam logic [GAIN_W-1:0] GAIN_STEP  = 35'd206158434;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 35'd10307921700;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [15:0]        channels;
    logic [31:0]        rate;
    logic [15:0]        depth;
    status_e            status;
    logic               eos;
  } result_t;

  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [7:0]  b,
                                           input logic [1:0]  idx);
    logic [31:0] w;
    w = word;
    w[{idx, 3'b000} +: 8] = b;
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wcp_parser.sv
// ----------------------------------------------------------------------------
// wcp_parser: RIFF/WAV chunk walker
// Tracks the parse phase and chunk counters one file byte per beat, captures
// the fmt fields and pairs data bytes into raw signed samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            beat_i,
  input  wire logic [7:0]      file_byte_i,
  input  wire logic            final_byte_i,
  output logic                 res_valid_o,
  output wcp_pkg::result_t     res_o
);

  wcp_pkg::phase_e phase_q, phase_d, phase_s;
  logic [31:0] pos_q, pos_d, pos_s;
  logic [31:0] tag_q, tag_d, tag_s;
  logic [31:0] len_q, len_d, len_s;
  logic [31:0] left_q, left_d, left_s;
  logic [15:0] chan_q, chan_d, chan_s;
  logic [31:0] rate_q, rate_d, rate_s;
  logic [15:0] depth_q, depth_d, depth_s;
  logic [8:0]  hold_q, hold_d, hold_s;

  logic [31:0] tag_shift;
  logic [31:0] len_put;
  logic [31:0] left_dec;
  logic [31:0] pos_inc;
  logic [31:0] rate_put;
  logic [31:0] chan_put;
  logic [31:0] depth_put;

  assign tag_shift = {tag_q[23:0], file_byte_i};
  assign len_put   = wcp_pkg::put_byte(len_q, file_byte_i, pos_q[1:0]);
  assign left_dec  = left_q - 32'd1;
  assign pos_inc   = pos_q + 32'd1;
  assign rate_put  = wcp_pkg::put_byte(rate_q, file_byte_i, pos_q[1:0]);
  assign chan_put  = wcp_pkg::put_byte({16'd0, chan_q}, file_byte_i, {1'b0, pos_q[0]});
  assign depth_put = wcp_pkg::put_byte({16'd0, depth_q}, file_byte_i, {1'b0, pos_q[0]});

  // Next state: step values first, then the restart on the final byte.
  always_comb begin
    phase_s = phase_q;
    pos_s   = pos_q;
    tag_s   = tag_q;
    len_s   = len_q;
    left_s  = left_q;
    chan_s  = chan_q;
    rate_s  = rate_q;
    depth_s = depth_q;
    hold_s  = hold_q;

    case (phase_q)
      wcp_pkg::PH_RIFF: begin
        tag_s = tag_shift;
        if (pos_q == wcp_pkg::RIFF_MAGIC_LAST && tag_shift != wcp_pkg::TAG_RIFF) begin
          phase_s = wcp_pkg::PH_DONE;
        end else if (pos_q == wcp_pkg::RIFF_HDR_LAST) begin
          phase_s = wcp_pkg::PH_HDR;
          pos_s   = '0;
          tag_s   = '0;
          len_s   = '0;
        end else begin
          pos_s = pos_inc;
        end
      end
      wcp_pkg::PH_HDR: begin
        if (pos_q[31:2] == 30'd0) begin
          tag_s = tag_shift;
        end else begin
          len_s = len_put;
        end
        pos_s = pos_inc;
        if (pos_q == wcp_pkg::CHUNK_HDR_LAST) begin
          pos_s  = '0;
          left_s = len_put;
          if (tag_q == wcp_pkg::TAG_DATA) begin
            if (len_put == '0) begin
              phase_s = wcp_pkg::PH_DONE;
            end else begin
              hold_s  = '0;
              phase_s = wcp_pkg::PH_DATA;
            end
          end else if (len_put == '0) begin
            phase_s = wcp_pkg::PH_HDR;
            tag_s   = '0;
            len_s   = '0;
          end else begin
            phase_s = wcp_pkg::PH_BODY;
          end
        end
      end
      wcp_pkg::PH_BODY: begin
        if (tag_q == wcp_pkg::TAG_FMT) begin
          if (pos_q == 32'd2 || pos_q == 32'd3) begin
            chan_s = chan_put[15:0];
          end else if (pos_q >= 32'd4 && pos_q <= 32'd7) begin
            rate_s = rate_put;
          end else if (pos_q == 32'd14 || pos_q == 32'd15) begin
            depth_s = depth_put[15:0];
          end
        end
        if (pos_q != '1) begin
          pos_s = pos_inc;
        end
        left_s = left_dec;
        if (left_dec == '0) begin
          if (len_q[0]) begin
            phase_s = wcp_pkg::PH_PAD;
          end else begin
            phase_s = wcp_pkg::PH_HDR;
            pos_s   = '0;
            tag_s   = '0;
            len_s   = '0;
          end
        end
      end
      wcp_pkg::PH_PAD: begin
        phase_s = wcp_pkg::PH_HDR;
        pos_s   = '0;
        tag_s   = '0;
        len_s   = '0;
      end
      wcp_pkg::PH_DATA: begin
        left_s = left_dec;
        if (!hold_q[8]) begin
          hold_s = {1'b1, file_byte_i};
          if (left_dec == '0) begin
            phase_s = wcp_pkg::PH_DONE;
          end
        end else begin
          hold_s = '0;
          if (left_dec <= 32'd1) begin
            phase_s = wcp_pkg::PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    if (final_byte_i) begin
      phase_d = wcp_pkg::PH_RIFF;
      pos_d   = '0;
      tag_d   = '0;
      len_d   = '0;
      left_d  = '0;
      chan_d  = wcp_pkg::DEF_CHANNELS;
      rate_d  = wcp_pkg::DEF_RATE;
      depth_d = wcp_pkg::DEF_DEPTH;
      hold_d  = '0;
    end else begin
      phase_d = phase_s;
      pos_d   = pos_s;
      tag_d   = tag_s;
      len_d   = len_s;
      left_d  = left_s;
      chan_d  = chan_s;
      rate_d  = rate_s;
      depth_d = depth_s;
      hold_d  = hold_s;
    end
  end

  // Result of this beat, if any.
  always_comb begin
    res_valid_o     = 1'b0;
    res_o.sample    = '0;
    res_o.channels  = chan_s;
    res_o.rate      = rate_s;
    res_o.depth     = depth_s;
    res_o.status    = wcp_pkg::ST_ERROR;
    res_o.eos       = 1'b1;

    case (phase_q)
      wcp_pkg::PH_RIFF: begin
        if (pos_q == wcp_pkg::RIFF_MAGIC_LAST && tag_shift != wcp_pkg::TAG_RIFF) begin
          res_valid_o = 1'b1;
        end
      end
      wcp_pkg::PH_HDR: begin
        if (pos_q == wcp_pkg::CHUNK_HDR_LAST && tag_q == wcp_pkg::TAG_DATA &&
            len_put == '0) begin
          res_valid_o = 1'b1;
        end
      end
      wcp_pkg::PH_DATA: begin
        if (!hold_q[8]) begin
          if (left_dec == '0) begin
            res_valid_o  = 1'b1;
            res_o.status = wcp_pkg::ST_ENDED;
          end
        end else begin
          res_valid_o  = 1'b1;
          res_o.status = wcp_pkg::ST_SAMPLE;
          res_o.sample = {file_byte_i, hold_q[7:0]};
          res_o.eos    = (left_dec <= 32'd1);
        end
      end
      default: begin
      end
    endcase

    // Close the file with one result if this byte gave none.
    if (final_byte_i && !res_valid_o && phase_s != wcp_pkg::PH_DONE) begin
      res_valid_o  = 1'b1;
      res_o.sample = '0;
      res_o.eos    = 1'b1;
      res_o.status = (phase_s == wcp_pkg::PH_DATA) ? wcp_pkg::ST_ENDED
                                                   : wcp_pkg::ST_ERROR;
    end

    res_valid_o = res_valid_o & beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wcp_pkg::PH_RIFF;
      pos_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
      chan_q  <= wcp_pkg::DEF_CHANNELS;
      rate_q  <= wcp_pkg::DEF_RATE;
      depth_q <= wcp_pkg::DEF_DEPTH;
      hold_q  <= '0;
    end else if (beat_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      left_q  <= left_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      depth_q <= depth_d;
      hold_q  <= hold_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wcp_scaler.sv
// ----------------------------------------------------------------------------
// wcp_scaler: volume scaling of one 16-bit sample
// Multiplies the sample magnitude by the precomputed gain, takes the top bits
// and restores the sign, which truncates towards zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcp_scaler (
  input  wire logic signed [15:0]                sample_i,
  input  wire logic [wcp_pkg::GAIN_W-1:0]        gain_i,
  output logic signed [15:0]                     scaled_o
);

  localparam int unsigned ProdW = 16 + wcp_pkg::GAIN_W;

  logic [16:0]      neg_ext;
  logic [15:0]      mag;
  logic [ProdW-1:0] prod;
  logic [15:0]      quot;

  assign neg_ext  = 17'd0 - {sample_i[15], sample_i};
  assign mag      = sample_i[15] ? neg_ext[15:0] : sample_i;
  assign prod     = ProdW'(mag) * ProdW'(gain_i);
  assign quot     = prod[wcp_pkg::RECIP_SHIFT +: 16];
  assign scaled_o = sample_i[15] ? (16'd0 - quot) : quot;

endmodule

`default_nettype wire

>>> rtl/wav_chunk_parser_volume_scaler.sv
// ----------------------------------------------------------------------------
// wav_chunk_parser_volume_scaler: WAV byte stream to scaled PCM16 samples
// Walks the RIFF chunks of a WAV file, captures the fmt fields and emits
// volume-scaled samples from the data chunk.
// ----------------------------------------------------------------------------
// Feed the file one byte per beat, with final_byte_i high on its last byte;
// the block then starts over for the next file with the fmt defaults of
// 2 channels, 44100 Hz and 16 bits. Every beat is parsed in the cycle it is
// accepted and its result, if it has one, lands in the output register at the
// same edge, so one byte is taken every cycle unless stalled and a result
// follows in the next cycle. The input stalls only while a result sits in
// the output register and the consumer stalls it. Every second data byte gives
// a sample scaled to trunc(s * volume * 6 / 1000); a bad RIFF magic, an empty
// data chunk or a file that ends before its data gives status 2, and a data
// chunk cut short gives status 1. The volume register (0..100, larger writes
// clamp to 100, reset 50) may be written only while no beat is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wav_chunk_parser_volume_scaler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         file_byte_i,
  input  wire logic               final_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      scaled_sample_o,
  output logic [15:0]             channel_count_o,
  output logic [31:0]             rate_hz_o,
  output logic [15:0]             bits_per_sample_o,
  output logic [1:0]              status_o,
  output logic                    end_of_stream_o,
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_wdata_i
);

  logic                          beat;
  logic                          res_valid;
  wcp_pkg::result_t              res;
  logic signed [15:0]            scaled;

  logic [6:0]                    vol_sat;
  logic [wcp_pkg::GAIN_W-1:0]    gain_q, gain_d;

  logic                          out_valid_q, out_valid_d;
  wcp_pkg::result_t              out_q, out_d;

  // Hold the input only while a finished result waits on a stalled consumer.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign beat       = in_valid_i & ~in_stall_o;

  // Clamp the volume and fold the fixed power limit and 1/1000 into one gain.
  assign vol_sat = (cfg_wdata_i > wcp_pkg::VOL_MAX) ? wcp_pkg::VOL_MAX : cfg_wdata_i;
  assign gain_d  = wcp_pkg::GAIN_W'(vol_sat) * wcp_pkg::GAIN_STEP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= wcp_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= gain_d;
    end
  end

  wcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .file_byte_i  (file_byte_i),
    .final_byte_i (final_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wcp_scaler u_scaler (
    .sample_i (res.sample),
    .gain_i   (gain_q),
    .scaled_o (scaled)
  );

  // Load the output register on a beat with a result; drop it once taken.
  always_comb begin
    out_d        = res;
    out_d.sample = scaled;
    out_valid_d  = out_valid_q;
    if (beat && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && res_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scaled_sample_o   = out_q.sample;
  assign channel_count_o   = out_q.channels;
  assign rate_hz_o         = out_q.rate;
  assign bits_per_sample_o = out_q.depth;
  assign status_o          = out_q.status;
  assign end_of_stream_o   = out_q.eos;

endmodule

`default_nettype wire

>>> tb/sv/tb_wav_chunk_parser_volume_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_chunk_parser_volume_scaler: self-checking bench for the WAV parser
// Feeds whole WAV files one byte per beat and predicts every result beat with
// a cycle-free model of the chunk walk, the fmt capture and the volume scaling.
// Directed files cover sample and fmt extremes, bad magic, empty, short and
// odd chunks, early file ends and one long output hold-off. Random files
// follow, mostly well formed, under bursty input and random output stalls.
// ----------------------------------------------------------------------------

module tb_wav_chunk_parser_volume_scaler;
  import wcp_pkg::*;

  localparam int unsigned CLK_PERIOD      = 4;
  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  // Results land in the cycle after their byte; the settle cycles cover it.
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned RANDOM_BYTES    = 550;
  localparam logic [31:0] TAG_WAVE        = 32'h5741_5645;
  localparam logic [31:0] TAG_LIST        = 32'h4C49_5354;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_style_e;

  // DUT pins; every input starts at a known value.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         file_byte_i = '0;
  logic               final_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] scaled_sample_o;
  logic [15:0]        channel_count_o;
  logic [31:0]        rate_hz_o;
  logic [15:0]        bits_per_sample_o;
  logic [1:0]         status_o;
  logic               end_of_stream_o;
  logic               cfg_we_i    = 1'b0;
  logic [6:0]         cfg_wdata_i = '0;

  // Parser state as the bench sees it.
  phase_e      ph;
  logic [31:0] pos;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] bytes_left;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate_hz;
  logic [15:0] fmt_bits;
  logic        low_held;
  logic [7:0]  low_byte;
  logic [6:0]  vol;

  // Result beats predicted but not yet seen, oldest first.
  result_t     due_results[$];
  result_t     due;
  logic [7:0]  file_bytes[$];

  int unsigned  fault_count  = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  bytes_fed    = 0;
  int unsigned  burst_left   = 0;
  bit           gaps_on      = 1'b1;
  stall_style_e stall_style  = STALL_RANDOM;
  bit           hold_request = 1'b0;
  int unsigned  hold_left    = 0;
  int unsigned  pattern_step = 0;

  wav_chunk_parser_volume_scaler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .file_byte_i       (file_byte_i),
    .final_byte_i      (final_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .scaled_sample_o   (scaled_sample_o),
    .channel_count_o   (channel_count_o),
    .rate_hz_o         (rate_hz_o),
    .bits_per_sample_o (bits_per_sample_o),
    .status_o          (status_o),
    .end_of_stream_o   (end_of_stream_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Drop every per-file field back to its default.
  task automatic restart_file();
    ph          = PH_RIFF;
    pos         = '0;
    tag_acc     = '0;
    chunk_len   = '0;
    bytes_left  = '0;
    fmt_chans   = DEF_CHANNELS;
    fmt_rate_hz = DEF_RATE;
    fmt_bits    = DEF_DEPTH;
    low_held    = 1'b0;
    low_byte    = '0;
  endtask

  task automatic open_header();
    ph        = PH_HDR;
    pos       = '0;
    tag_acc   = '0;
    chunk_len = '0;
  endtask

  // Every result beat carries the fmt fields as they stand when it is made.
  task automatic queue_result(input logic signed [15:0] smp, input status_e st,
                              input logic eos);
    result_t r;
    r.sample   = smp;
    r.channels = fmt_chans;
    r.rate     = fmt_rate_hz;
    r.depth    = fmt_bits;
    r.status   = st;
    r.eos      = eos;
    due_results.push_back(r);
  endtask

  // Advance the parse by one accepted byte and queue the beat it yields.
  task automatic parse_wav_byte(input logic [7:0] b, input logic fin);
    logic        gave;
    logic [15:0] pair;
    int          s;
    int          v;
    gave = 1'b0;
    case (ph)
      PH_RIFF: begin
        tag_acc = {tag_acc[23:0], b};
        if (pos == RIFF_MAGIC_LAST && tag_acc != TAG_RIFF) begin
          queue_result('0, ST_ERROR, 1'b1);
          gave = 1'b1;
          ph   = PH_DONE;
        end else begin
          pos++;
          if (pos > RIFF_HDR_LAST) open_header();
        end
      end
      PH_HDR: begin
        // Id comes big-end first as text, the length little-endian.
        if (pos < 4) tag_acc = {tag_acc[23:0], b};
        else chunk_len[8 * pos[1:0] +: 8] = b;
        pos++;
        if (pos > CHUNK_HDR_LAST) begin
          pos        = '0;
          bytes_left = chunk_len;
          if (tag_acc == TAG_DATA) begin
            if (chunk_len == 0) begin
              queue_result('0, ST_ERROR, 1'b1);
              gave = 1'b1;
              ph   = PH_DONE;
            end else begin
              low_held = 1'b0;
              ph       = PH_DATA;
            end
          end else if (chunk_len == 0) begin
            open_header();
          end else begin
            ph = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (tag_acc == TAG_FMT) begin
          if (pos == 2 || pos == 3) fmt_chans[8 * pos[0] +: 8] = b;
          else if (pos >= 4 && pos <= 7) fmt_rate_hz[8 * pos[1:0] +: 8] = b;
          else if (pos == 14 || pos == 15) fmt_bits[8 * pos[0] +: 8] = b;
        end
        if (pos != '1) pos++;
        bytes_left--;
        if (bytes_left == 0) begin
          if (chunk_len[0]) ph = PH_PAD;
          else open_header();
        end
      end
      PH_PAD: open_header();
      PH_DATA: begin
        bytes_left--;
        if (!low_held) begin
          low_held = 1'b1;
          low_byte = b;
          // A lone last byte cannot make a sample.
          if (bytes_left == 0) begin
            queue_result('0, ST_ENDED, 1'b1);
            gave = 1'b1;
            ph   = PH_DONE;
          end
        end else begin
          pair     = {b, low_byte};
          s        = $signed(pair);
          v        = (vol == 0) ? 0 : (s * int'(vol) * 6) / 1000;
          low_held = 1'b0;
          queue_result(v[15:0], ST_SAMPLE, bytes_left <= 1);
          gave = 1'b1;
          if (bytes_left <= 1) ph = PH_DONE;
        end
      end
      default: ;
    endcase
    // A file that stops before its stream ends still owes one closing beat.
    if (fin) begin
      if (!gave && ph != PH_DONE) queue_result('0, (ph == PH_DATA) ? ST_ENDED : ST_ERROR, 1'b1);
      restart_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // File assembly
  // ---------------------------------------------------------------------------

  function automatic void add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8 * i +: 8]);
  endfunction

  function automatic void add_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void add_riff();
    add_tag(TAG_RIFF);
    add_le32($urandom);
    add_tag(TAG_WAVE);
  endfunction

  // fmt chunk cut to len bytes; bytes past the usual sixteen are filler.
  function automatic void add_fmt(input logic [31:0] len, input logic [15:0] chans,
                                  input logic [31:0] rate, input logic [15:0] depth);
    logic [127:0] body;
    body = {depth, 16'd4, $urandom, rate, chans, 16'd1};
    add_tag(TAG_FMT);
    add_le32(len);
    for (int i = 0; i < len; i++) file_bytes.push_back(i < 16 ? body[8 * i +: 8] : 8'($urandom));
    if (len[0]) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_chunk(input logic [31:0] t, input logic [31:0] len);
    add_tag(t);
    add_le32(len);
    for (int i = 0; i < len; i++) file_bytes.push_back(8'($urandom));
    if (len[0]) file_bytes.push_back(8'($urandom));
  endfunction

  // Data header with a stated length and n random payload bytes after it.
  function automatic void add_data(input logic [31:0] len, input int unsigned n);
    add_tag(TAG_DATA);
    add_le32(len);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until the block takes it; between bursts
  // drop valid for a random pause.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i   <= 1'b1;
    file_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    bytes_fed++;
    parse_wav_byte(b, fin);
  endtask

  task automatic send_file();
    int unsigned n;
    n = file_bytes.size();
    for (int unsigned i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
    file_bytes.delete();
  endtask

  // Let every owed beat drain, then the settle cycles for a byte in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_volume(input logic [6:0] pct);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pct;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vol = (pct > VOL_MAX) ? VOL_MAX : pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full-scale, zero and minus-one samples across volume extremes and clamp,
  // with the fmt fields pushed to their limits.
  task automatic test_sample_extremes();
    logic [7:0] extremes [10] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00,
                                  8'hFF, 8'hFF, 8'h01, 8'h00};
    logic [6:0] vols [4] = '{VOL_MAX, 7'd0, 7'd127, 7'd1};
    // First file runs at the reset volume with no fmt chunk: defaults stand.
    add_riff();
    add_data(10, 0);
    foreach (extremes[i]) file_bytes.push_back(extremes[i]);
    send_file();
    foreach (vols[k]) begin
      set_volume(vols[k]);
      add_riff();
      if (k[0]) add_fmt(16, 16'h0000, 32'h0000_0000, 16'hFFFF);
      else add_fmt(16, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
      add_data(10, 0);
      foreach (extremes[i]) file_bytes.push_back(extremes[i]);
      send_file();
    end
    set_volume(VOL_RESET);
  endtask

  // Wrong magic gives an error at its fourth byte; a file cut inside the magic
  // gives one on its last byte.
  task automatic test_bad_magic();
    add_tag(32'h5249_4658);
    repeat (3) file_bytes.push_back(8'($urandom));
    send_file();
    add_tag(TAG_RIFF);
    void'(file_bytes.pop_back());
    void'(file_bytes.pop_back());
    send_file();
    file_bytes.push_back(8'h52);
    send_file();
  endtask

  // Zero-length data chunk after an odd chunk with its pad byte.
  task automatic test_empty_data();
    add_riff();
    add_chunk(TAG_LIST, 3);
    add_data(0, 2);
    send_file();
  endtask

  // fmt chunks that stop short of some fields, empty and odd.
  task automatic test_short_fmt();
    add_riff();
    add_fmt(5, 16'h1234, 32'hA1B2_C3D4, 16'h0018);
    add_data(4, 4);
    send_file();
    add_riff();
    add_fmt(0, 16'h0001, 32'h0000_1F40, 16'h0008);
    add_fmt(15, 16'h0006, 32'h0001_7700, 16'h0020);
    add_data(2, 2);
    send_file();
  endtask

  // Odd data lengths: trailing byte dropped, a one-byte chunk ends with no sample.
  task automatic test_odd_data();
    add_riff();
    add_data(5, 5);
    repeat (3) file_bytes.push_back(8'($urandom));
    send_file();
    add_riff();
    add_data(1, 1);
    send_file();
    add_riff();
    add_data(3, 3);
    send_file();
  endtask

  // Files that stop early: inside data, inside a chunk header, inside a body,
  // and inside a data chunk of enormous stated length.
  task automatic test_truncated();
    add_riff();
    add_data(20, 3);
    send_file();
    add_riff();
    add_tag(TAG_DATA);
    file_bytes.push_back(8'h08);
    send_file();
    add_riff();
    add_tag(TAG_LIST);
    add_le32(32'd40);
    repeat (5) file_bytes.push_back(8'($urandom));
    send_file();
    add_riff();
    add_data(32'hFFFF_FFFF, 7);
    send_file();
  endtask

  // Hold the output off long enough that the block fills and stalls its input.
  task automatic test_long_hold_off();
    gaps_on      = 1'b0;
    stall_style  = STALL_NONE;
    hold_request = 1'b1;
    add_riff();
    add_data(80, 80);
    send_file();
    gaps_on     = 1'b1;
    stall_style = STALL_RANDOM;
  endtask

  // Mostly well-formed files with random content; the rest is noise, broken
  // magic or files cut short.
  task automatic test_random_files();
    int unsigned start_count;
    int unsigned kind;
    int unsigned data_len;
    int unsigned cut;
    start_count = bytes_fed;
    while (bytes_fed - start_count < RANDOM_BYTES) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      gaps_on     = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) set_volume(7'($urandom_range(0, 127)));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
      end else if (kind == 1) begin
        add_tag(TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)));
        repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom));
      end else begin
        add_riff();
        if ($urandom_range(0, 4) != 0) begin
          add_fmt(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16,
                  16'($urandom), $urandom, 16'($urandom));
        end
        repeat ($urandom_range(0, 2)) add_chunk($urandom, $urandom_range(0, 9));
        case ($urandom_range(0, 19))
          0: add_data(0, $urandom_range(0, 3));
          1: add_data(32'h8000_0000 | $urandom, $urandom_range(1, 20));
          default: begin
            data_len = $urandom_range(1, 40);
            add_data(data_len, data_len);
          end
        endcase
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 6) == 0) begin
          cut = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
      end
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    vol = VOL_RESET;
    restart_file();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sample_extremes();
    test_bad_magic();
    test_empty_data();
    test_short_fmt();
    test_odd_data();
    test_truncated();
    test_long_hold_off();
    test_random_files();

    drain();
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: a long hold-off on request, otherwise the current stall style.
  always @(posedge clk_i) begin
    pattern_step++;
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_style)
        STALL_NONE:    out_stall_i <= 1'b0;
        STALL_RANDOM:  out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_PATTERN: out_stall_i <= (pattern_step % 7) < 3;
        default:       out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected result beat: status %0d, sample %0d", status_o, scaled_sample_o);
        fault_count++;
      end else begin
        due = due_results.pop_front();
        if (scaled_sample_o !== due.sample) begin
          $error("scaled_sample: expected %0d, got %0d", due.sample, scaled_sample_o);
          fault_count++;
        end
        if (channel_count_o !== due.channels) begin
          $error("channel_count: expected %0d, got %0d", due.channels, channel_count_o);
          fault_count++;
        end
        if (rate_hz_o !== due.rate) begin
          $error("rate_hz: expected %0d, got %0d", due.rate, rate_hz_o);
          fault_count++;
        end
        if (bits_per_sample_o !== due.depth) begin
          $error("bits_per_sample: expected %0d, got %0d", due.depth, bits_per_sample_o);
          fault_count++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status_o);
          fault_count++;
        end
        if (end_of_stream_o !== due.eos) begin
          $error("end_of_stream: expected %0d, got %0d", due.eos, end_of_stream_o);
          fault_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
